>>> rtl/slpc_pkg.sv
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types and constants for the sync/length packet classifier.
// ----------------------------------------------------------------------------
package slpc_pkg;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_GOT_AA,
        PH_GOT_SYNC,
        PH_BODY
    } phase_t;

    localparam logic [3:0] CLS_HEARTBEAT   = 4'd0;
    localparam logic [3:0] CLS_TONE        = 4'd1;
    localparam logic [3:0] CLS_TONE_BADLEN = 4'd2;
    localparam logic [3:0] CLS_TONE_BADPAR = 4'd3;
    localparam logic [3:0] CLS_TOO_SHORT   = 4'd4;
    localparam logic [3:0] CLS_DUPLICATE   = 4'd5;
    localparam logic [3:0] CLS_MENU_DROP   = 4'd6;
    localparam logic [3:0] CLS_DISPLAY     = 4'd7;
    localparam logic [3:0] CLS_LEN_ERR     = 4'd8;

    localparam logic [7:0] SYNC_FIRST      = 8'hAA;
    localparam logic [7:0] SYNC_SECOND     = 8'h55;
    localparam logic [7:0] HEARTBEAT_ID    = 8'h02;
    localparam logic [7:0] TONE_ID_HI      = 8'h20;
    localparam logic [7:0] TONE_ID_LO      = 8'h02;
    localparam logic [7:0] MIN_LENGTH      = 8'd3;
    localparam logic [7:0] HEARTBEAT_LEN   = 8'd4;
    localparam logic [7:0] SHORT_LIMIT     = 8'd5;
    localparam logic [7:0] TONE_LEN        = 8'd10;
    localparam logic [7:0] TONE_VOL_LEN    = 8'd11;
    localparam logic [7:0] MAX_LEN_RESET   = 8'd255;
    localparam logic [7:0] VOLUME_MAX      = 8'd100;
    localparam int         FIELD_FIRST     = 3;
    localparam int         FIELD_COUNT     = 8;

    typedef struct packed {
        logic [3:0]  packet_class;
        logic [7:0]  packet_length;
        logic [15:0] frame_interval;
        logic [15:0] tone_frequency;
        logic [15:0] tone_duration;
        logic [6:0]  tone_volume;
        logic        volume_present;
        logic        frame_bank;
    } result_t;

endpackage

>>> rtl/slpc_ram.sv
// ----------------------------------------------------------------------------
// slpc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module slpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/slpc_parser.sv
// ----------------------------------------------------------------------------
// slpc_parser
// Sync hunt, length check, packet collection, duplicate detection against the
// frame banks and classification at the last byte of each packet.
// ----------------------------------------------------------------------------
module slpc_parser #(
    parameter int BANK_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              kind,
    input  logic [7:0]        data_byte,
    input  logic              in_menu,
    input  logic [7:0]        max_len,
    output logic              res_valid,
    output slpc_pkg::result_t res
);

    import slpc_pkg::*;

    localparam int AW = $clog2(2 * BANK_DEPTH);

    phase_t     phase_reg, phase_next;
    logic [7:0] exp_len_reg, exp_len_next;
    logic [7:0] idx_reg, idx_next;
    logic       mismatch_reg, mismatch_next;
    logic       bank_reg, bank_next;
    logic       last_valid_reg, last_valid_next;
    logic [7:0] last_len_reg, last_len_next;
    logic [7:0] field_reg [FIELD_COUNT];
    logic [7:0] field_next [FIELD_COUNT];

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    slpc_ram #(
        .WIDTH (8),
        .DEPTH (2 * BANK_DEPTH)
    ) u_banks (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            exp_len_reg    <= '0;
            idx_reg        <= '0;
            mismatch_reg   <= 1'b0;
            bank_reg       <= 1'b0;
            last_valid_reg <= 1'b0;
            last_len_reg   <= '0;
            for (int k = 0; k < FIELD_COUNT; k++)
            begin
                field_reg[k] <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            exp_len_reg    <= exp_len_next;
            idx_reg        <= idx_next;
            mismatch_reg   <= mismatch_next;
            bank_reg       <= bank_next;
            last_valid_reg <= last_valid_next;
            last_len_reg   <= last_len_next;
            for (int k = 0; k < FIELD_COUNT; k++)
            begin
                field_reg[k] <= field_next[k];
            end
        end
    end

    always_comb
    begin
        logic        fin;
        logic        in_bank;
        logic [7:0]  fin_len;
        logic [15:0] freq;
        logic [15:0] dur;

        phase_next      = phase_reg;
        exp_len_next    = exp_len_reg;
        idx_next        = idx_reg;
        mismatch_next   = mismatch_reg;
        bank_next       = bank_reg;
        last_valid_next = last_valid_reg;
        last_len_next   = last_len_reg;
        for (int k = 0; k < FIELD_COUNT; k++)
        begin
            field_next[k] = field_reg[k];
        end
        res_valid = 1'b0;
        res       = '0;
        wr_en     = 1'b0;
        fin       = 1'b0;
        fin_len   = exp_len_reg;
        in_bank   = (32'(idx_reg) < BANK_DEPTH);
        freq      = '0;
        dur       = '0;

        if (accept)
        begin
            if (kind)
            begin
                // disconnect: back to hunting, forget the last display frame
                phase_next      = PH_HUNT;
                exp_len_next    = '0;
                idx_next        = '0;
                mismatch_next   = 1'b0;
                last_valid_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        phase_next = (data_byte == SYNC_FIRST) ? PH_GOT_AA : PH_HUNT;
                    end
                    PH_GOT_AA:
                    begin
                        if (data_byte == SYNC_SECOND)
                        begin
                            phase_next = PH_GOT_SYNC;
                        end
                        else if (data_byte != SYNC_FIRST)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_GOT_SYNC:
                    begin
                        if (data_byte < MIN_LENGTH || data_byte > max_len)
                        begin
                            res_valid           = 1'b1;
                            res.packet_class    = CLS_LEN_ERR;
                            res.packet_length   = data_byte;
                            phase_next = (data_byte == SYNC_FIRST) ? PH_GOT_AA : PH_HUNT;
                        end
                        else
                        begin
                            // header bytes always match a stored frame of equal length
                            exp_len_next  = data_byte;
                            mismatch_next = 1'b0;
                            idx_next      = 8'(FIELD_FIRST);
                            if (data_byte == MIN_LENGTH)
                            begin
                                fin     = 1'b1;
                                fin_len = data_byte;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (in_bank)
                        begin
                            wr_en = 1'b1;
                            if (rd_data != data_byte)
                            begin
                                mismatch_next = 1'b1;
                            end
                        end
                        else
                        begin
                            mismatch_next = 1'b1;
                        end
                        for (int k = 0; k < FIELD_COUNT; k++)
                        begin
                            if (idx_reg == 8'(k + FIELD_FIRST))
                            begin
                                field_next[k] = data_byte;
                            end
                        end
                        idx_next = idx_reg + 8'd1;
                        if (idx_next >= exp_len_reg)
                        begin
                            fin     = 1'b1;
                            fin_len = exp_len_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end

        if (fin)
        begin
            phase_next        = PH_HUNT;
            idx_next          = '0;
            res_valid         = 1'b1;
            res.packet_length = fin_len;
            freq = {field_next[3], field_next[4]};
            dur  = {field_next[5], field_next[6]};
            if (fin_len == HEARTBEAT_LEN && field_next[0] == HEARTBEAT_ID)
            begin
                res.packet_class = CLS_HEARTBEAT;
            end
            else if (fin_len >= TONE_LEN && field_next[0] == TONE_ID_HI
                     && field_next[1] == TONE_ID_LO)
            begin
                if (fin_len != TONE_LEN && fin_len != TONE_VOL_LEN)
                begin
                    res.packet_class = CLS_TONE_BADLEN;
                end
                else
                begin
                    res.tone_frequency = freq;
                    res.tone_duration  = dur;
                    if (fin_len == TONE_VOL_LEN)
                    begin
                        res.tone_volume    = (field_next[7] > VOLUME_MAX) ?
                                             VOLUME_MAX[6:0] : field_next[7][6:0];
                        res.volume_present = 1'b1;
                    end
                    res.packet_class = (freq == '0 || dur == '0) ?
                                       CLS_TONE_BADPAR : CLS_TONE;
                end
            end
            else if (fin_len < SHORT_LIMIT)
            begin
                res.packet_class = CLS_TOO_SHORT;
            end
            else if (last_valid_reg && last_len_reg == fin_len && !mismatch_next)
            begin
                res.packet_class = CLS_DUPLICATE;
            end
            else if (in_menu)
            begin
                res.packet_class = CLS_MENU_DROP;
            end
            else
            begin
                bank_next          = ~bank_reg;
                last_valid_next    = 1'b1;
                last_len_next      = fin_len;
                res.packet_class   = CLS_DISPLAY;
                res.frame_interval = {field_next[0], field_next[1]};
                res.frame_bank     = ~bank_reg;
            end
        end
    end

    // frames are written into the idle bank and compared with the active one
    always_comb
    begin
        wr_addr = AW'((bank_reg ? 0 : BANK_DEPTH) + 32'(idx_reg));
        if (32'(idx_next) < BANK_DEPTH)
        begin
            rd_addr = AW'((bank_next ? BANK_DEPTH : 0) + 32'(idx_next));
        end
        else
        begin
            rd_addr = AW'(bank_next ? BANK_DEPTH : 0);
        end
    end

endmodule

>>> rtl/sync_length_packet_classifier_unit.sv
// ----------------------------------------------------------------------------
// sync_length_packet_classifier_unit
// Byte-stream packet classifier with sync hunt and display frame dedup.
// ----------------------------------------------------------------------------
// One input beat is taken every clock cycle unless a stalled result holds the
// output register; a result appears there on the cycle after the last byte of
// its packet (or after a rejected length byte), and the next beat is accepted
// alongside it if out_ready is high. Each body byte inside the bank makes one
// write to the idle bank and one compare with an active-bank word read ahead
// on the previous cycle. The banks need no clearing; the unit is ready at once.
module sync_length_packet_classifier_unit #(
    parameter int BANK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  logic        in_menu,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  packet_class,
    output logic [7:0]  packet_length,
    output logic [15:0] frame_interval,
    output logic [15:0] tone_frequency,
    output logic [15:0] tone_duration,
    output logic [6:0]  tone_volume,
    output logic        volume_present,
    output logic        frame_bank
);

    import slpc_pkg::*;

    logic [7:0] max_len_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg;
    result_t    res;
    logic       res_valid;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    slpc_parser #(
        .BANK_DEPTH (BANK_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .data_byte (data_byte),
        .in_menu   (in_menu),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign packet_class   = result_reg.packet_class;
    assign packet_length  = result_reg.packet_length;
    assign frame_interval = result_reg.frame_interval;
    assign tone_frequency = result_reg.tone_frequency;
    assign tone_duration  = result_reg.tone_duration;
    assign tone_volume    = result_reg.tone_volume;
    assign volume_present = result_reg.volume_present;
    assign frame_bank     = result_reg.frame_bank;

    // a result only replaces the output register once the old one has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !res_valid)
        else $error("result register overwritten while stalled");

    // a length error carries a length outside the accepted range
    a_len_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && packet_class == CLS_LEN_ERR
        |-> (packet_length < MIN_LENGTH || packet_length > max_len_reg))
        else $error("length error with an acceptable length");

    // the volume byte only accompanies a tone command of the right length
    a_volume_tone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && volume_present
        |-> (packet_class == CLS_TONE || packet_class == CLS_TONE_BADPAR)
            && packet_length == TONE_VOL_LEN)
        else $error("volume flag on a non-tone result");

endmodule

>>> bench/sync_length_packet_classifier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_packet_classifier_checker
// Watches the configuration, byte and result channels of the classifier.
// Keeps its own copy of the parser, the frame banks and the length limit,
// predicts the classification of every packet, and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sync_length_packet_classifier_checker #(
    parameter int BANK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  logic        in_menu,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  packet_class,
    input  logic [7:0]  packet_length,
    input  logic [15:0] frame_interval,
    input  logic [15:0] tone_frequency,
    input  logic [15:0] tone_duration,
    input  logic [6:0]  tone_volume,
    input  logic        volume_present,
    input  logic        frame_bank,

    output int          fail_count,
    output int          pending_results
);

    import slpc_pkg::*;

    result_t     predicted_classes[$];

    logic [7:0]  max_length;
    phase_t      parse_state;
    logic [7:0]  packet_len;
    logic [7:0]  byte_pos;
    logic [7:0]  frame_store [2][BANK_DEPTH];
    logic        active_bank;
    logic        last_frame_valid;
    logic [7:0]  last_frame_len;
    logic        frame_differs;
    logic [7:0]  field_bytes [FIELD_FIRST:FIELD_FIRST+FIELD_COUNT-1];

    function automatic void clear_model();
        int i;
        max_length       = MAX_LEN_RESET;
        parse_state      = PH_HUNT;
        packet_len       = '0;
        byte_pos         = '0;
        active_bank      = 1'b0;
        last_frame_valid = 1'b0;
        last_frame_len   = '0;
        frame_differs    = 1'b0;
        for (i = 0; i < BANK_DEPTH; i++)
        begin
            frame_store[0][i] = '0;
            frame_store[1][i] = '0;
        end
        for (i = FIELD_FIRST; i < FIELD_FIRST + FIELD_COUNT; i++)
            field_bytes[i] = '0;
        predicted_classes.delete();
    endfunction

    function automatic void queue_result(result_t r);
        predicted_classes.insert(predicted_classes.size(), r);
    endfunction

    // write into the idle bank, compare against the bank of the last frame
    function automatic void store_byte(int idx, logic [7:0] b);
        if (idx < BANK_DEPTH)
        begin
            if (frame_store[active_bank][idx] != b)
                frame_differs = 1'b1;
            frame_store[!active_bank][idx] = b;
        end
        else
        begin
            frame_differs = 1'b1;
        end
        if (idx >= FIELD_FIRST && idx < FIELD_FIRST + FIELD_COUNT)
            field_bytes[idx] = b;
    endfunction

    function automatic void close_packet(logic menu);
        result_t     r;
        logic [15:0] freq;
        logic [15:0] dur;
        r           = '0;
        r.packet_length = packet_len;
        parse_state = PH_HUNT;
        byte_pos    = '0;
        // frequency in bytes 6 and 7, duration in bytes 8 and 9
        freq = {field_bytes[6], field_bytes[7]};
        dur  = {field_bytes[8], field_bytes[9]};
        if (packet_len == HEARTBEAT_LEN && field_bytes[3] == HEARTBEAT_ID)
        begin
            r.packet_class = CLS_HEARTBEAT;
        end
        else if (packet_len >= TONE_LEN && field_bytes[3] == TONE_ID_HI
                 && field_bytes[4] == TONE_ID_LO)
        begin
            if (packet_len != TONE_LEN && packet_len != TONE_VOL_LEN)
            begin
                r.packet_class = CLS_TONE_BADLEN;
            end
            else
            begin
                r.tone_frequency = freq;
                r.tone_duration  = dur;
                if (packet_len == TONE_VOL_LEN)
                begin
                    r.tone_volume    = (field_bytes[10] > VOLUME_MAX) ?
                                       VOLUME_MAX[6:0] : field_bytes[10][6:0];
                    r.volume_present = 1'b1;
                end
                r.packet_class = (freq == '0 || dur == '0) ? CLS_TONE_BADPAR : CLS_TONE;
            end
        end
        else if (packet_len < SHORT_LIMIT)
        begin
            r.packet_class = CLS_TOO_SHORT;
        end
        else if (last_frame_valid && last_frame_len == packet_len && !frame_differs)
        begin
            r.packet_class = CLS_DUPLICATE;
        end
        else if (menu)
        begin
            r.packet_class = CLS_MENU_DROP;
        end
        else
        begin
            active_bank      = !active_bank;
            last_frame_valid = 1'b1;
            last_frame_len   = packet_len;
            r.packet_class   = CLS_DISPLAY;
            r.frame_interval = {field_bytes[3], field_bytes[4]};
            r.frame_bank     = active_bank;
        end
        queue_result(r);
    endfunction

    function automatic void classify_beat(logic clear_req, logic [7:0] b, logic menu);
        result_t r;
        if (clear_req)
        begin
            parse_state      = PH_HUNT;
            packet_len       = '0;
            byte_pos         = '0;
            frame_differs    = 1'b0;
            last_frame_valid = 1'b0;
            return;
        end
        case (parse_state)
            PH_GOT_AA:
            begin
                if (b == SYNC_SECOND)
                    parse_state = PH_GOT_SYNC;
                else if (b != SYNC_FIRST)
                    parse_state = PH_HUNT;
            end
            PH_GOT_SYNC:
            begin
                if (b < MIN_LENGTH || b > max_length)
                begin
                    r               = '0;
                    r.packet_class  = CLS_LEN_ERR;
                    r.packet_length = b;
                    queue_result(r);
                    // a rejected length byte may itself open a new sync pair
                    parse_state = (b == SYNC_FIRST) ? PH_GOT_AA : PH_HUNT;
                end
                else
                begin
                    packet_len    = b;
                    frame_differs = 1'b0;
                    store_byte(0, SYNC_FIRST);
                    store_byte(1, SYNC_SECOND);
                    store_byte(2, b);
                    byte_pos = 8'd3;
                    if (packet_len == MIN_LENGTH)
                        close_packet(menu);
                    else
                        parse_state = PH_BODY;
                end
            end
            PH_BODY:
            begin
                store_byte(int'(byte_pos), b);
                byte_pos = byte_pos + 8'd1;
                if (byte_pos >= packet_len)
                    close_packet(menu);
            end
            default:
            begin
                parse_state = (b == SYNC_FIRST) ? PH_GOT_AA : PH_HUNT;
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        result_t e;
        if (predicted_classes.size() == 0)
        begin
            $error("unexpected result beat: class %0d, length %0d",
                   packet_class, packet_length);
            fail_count++;
            return;
        end
        e = predicted_classes[0];
        predicted_classes.delete(0);
        compare_field("packet_class",   16'(e.packet_class),   16'(packet_class));
        compare_field("packet_length",  16'(e.packet_length),  16'(packet_length));
        compare_field("frame_interval", e.frame_interval,      frame_interval);
        compare_field("tone_frequency", e.tone_frequency,      tone_frequency);
        compare_field("tone_duration",  e.tone_duration,       tone_duration);
        compare_field("tone_volume",    16'(e.tone_volume),    16'(tone_volume));
        compare_field("volume_present", 16'(e.volume_present), 16'(volume_present));
        compare_field("frame_bank",     16'(e.frame_bank),     16'(frame_bank));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            fail_count = 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            // a beat taken at this edge still sees the old length limit
            if (in_valid && in_ready)
                classify_beat(kind, data_byte, in_menu);
            if (cfg_valid && cfg_ready)
                max_length = cfg_data;
            pending_results <= predicted_classes.size();
        end
    end

endmodule

>>> bench/sync_length_packet_classifier_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_packet_classifier_unit_test
// Drives byte streams into the packet classifier: a directed run over every
// packet class, then random well-formed packets mixed with noise, broken
// packets and stream clears, under several length limits and with idle
// cycles on the byte and result channels. A checker alongside predicts
// and compares every result.
// ----------------------------------------------------------------------------
module sync_length_packet_classifier_unit_test;

    import slpc_pkg::*;

    localparam int BANK_DEPTH     = 256;
    localparam int PHASE_BEATS    = 85;
    localparam int DRAIN_SLACK    = 4;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        in_menu;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  packet_class;
    logic [7:0]  packet_length;
    logic [15:0] frame_interval;
    logic [15:0] tone_frequency;
    logic [15:0] tone_duration;
    logic [6:0]  tone_volume;
    logic        volume_present;
    logic        frame_bank;

    int          fail_count;
    int          pending_results;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          beats_sent;
    int          stall_cycles = 0;
    logic [7:0]  cur_max;
    logic [7:0]  pkt_bytes[$];
    logic [7:0]  last_frame_bytes[$];

    sync_length_packet_classifier_unit #(
        .BANK_DEPTH(BANK_DEPTH)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .in_menu        (in_menu),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .packet_class   (packet_class),
        .packet_length  (packet_length),
        .frame_interval (frame_interval),
        .tone_frequency (tone_frequency),
        .tone_duration  (tone_duration),
        .tone_volume    (tone_volume),
        .volume_present (volume_present),
        .frame_bank     (frame_bank)
    );

    sync_length_packet_classifier_checker #(
        .BANK_DEPTH(BANK_DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .data_byte       (data_byte),
        .in_menu         (in_menu),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .packet_class    (packet_class),
        .packet_length   (packet_length),
        .frame_interval  (frame_interval),
        .tone_frequency  (tone_frequency),
        .tone_duration   (tone_duration),
        .tone_volume     (tone_volume),
        .volume_present  (volume_present),
        .frame_bank      (frame_bank),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("sync_length_packet_classifier_unit_test: FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] rand_word();
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic send_beat(input logic clear_req, input logic [7:0] b, input logic menu);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= clear_req;
        data_byte <= b;
        in_menu   <= menu;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic clear_stream();
        send_beat(1'b1, rand_byte(), rand_bit());
    endtask

    // menu flag only matters on the last beat of a packet
    task automatic send_frame(input int count, input logic menu_at_end);
        int i;
        for (i = 0; i < count; i++)
            send_beat(1'b0, pkt_bytes[i], (i == count - 1) ? menu_at_end : rand_bit());
    endtask

    task automatic send_all(input logic menu_at_end);
        send_frame(pkt_bytes.size(), menu_at_end);
    endtask

    task automatic append_byte(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endtask

    task automatic start_frame(input logic [7:0] len);
        pkt_bytes.delete();
        append_byte(SYNC_FIRST);
        append_byte(SYNC_SECOND);
        append_byte(len);
    endtask

    task automatic make_display(input logic [7:0] len, input logic [15:0] interval);
        start_frame(len);
        append_byte(interval[15:8]);
        append_byte(interval[7:0]);
        while (pkt_bytes.size() < len)
            append_byte(rand_byte());
    endtask

    task automatic make_tone(input logic [7:0] len, input logic [15:0] freq,
                             input logic [15:0] dur, input logic [7:0] vol);
        start_frame(len);
        append_byte(TONE_ID_HI);
        append_byte(TONE_ID_LO);
        append_byte(rand_byte());
        append_byte(freq[15:8]);
        append_byte(freq[7:0]);
        append_byte(dur[15:8]);
        append_byte(dur[7:0]);
        if (len >= TONE_VOL_LEN)
            append_byte(vol);
        while (pkt_bytes.size() < len)
            append_byte(rand_byte());
    endtask

    task automatic make_heartbeat();
        start_frame(HEARTBEAT_LEN);
        append_byte(HEARTBEAT_ID);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_max = value;
    endtask

    function automatic logic [7:0] pick_display_len();
        int hi;
        hi = (cur_max < 40) ? int'(cur_max) : 40;
        if (cur_max < SHORT_LIMIT)
            return SHORT_LIMIT;
        if ($urandom_range(59) == 0)
            return cur_max;
        return 8'($urandom_range(hi, SHORT_LIMIT));
    endfunction

    function automatic logic [15:0] pick_tone_word();
        if ($urandom_range(5) == 0)
            return 16'h0000;
        return rand_word();
    endfunction

    task automatic run_directed();
        make_heartbeat();
        send_all(1'b0);
        start_frame(MIN_LENGTH);
        send_all(1'b1);
        start_frame(HEARTBEAT_LEN);
        append_byte(8'h00);
        send_all(1'b0);
        make_tone(TONE_LEN, 16'hFFFF, 16'h0001, 8'h00);
        send_all(1'b0);
        make_tone(TONE_VOL_LEN, 16'h0001, 16'hFFFF, 8'hFF);
        send_all(1'b0);
        make_tone(TONE_VOL_LEN, 16'h8000, 16'h0100, VOLUME_MAX);
        send_all(1'b1);
        make_tone(TONE_VOL_LEN, 16'h0000, 16'h1234, 8'h00);
        send_all(1'b0);
        make_tone(TONE_LEN, 16'h1234, 16'h0000, 8'h00);
        send_all(1'b0);
        make_tone(TONE_VOL_LEN + 8'd1, 16'h1111, 16'h2222, 8'h33);
        send_all(1'b0);
        // display, then its repeat with and without menu mode
        make_display(8'd5, 16'hFFFF);
        send_all(1'b0);
        send_all(1'b0);
        send_all(1'b1);
        make_display(8'd6, 16'h0000);
        send_all(1'b1);
        send_all(1'b0);
        start_frame(8'd0);
        send_all(1'b0);
        start_frame(MIN_LENGTH - 8'd1);
        send_all(1'b0);
        // noise, then a doubled first sync byte
        send_beat(1'b0, 8'hFF, 1'b1);
        send_beat(1'b0, SYNC_FIRST, 1'b0);
        make_display(8'd7, 16'h00FF);
        send_all(1'b0);
        // clear part way through, then the last frame is no longer known
        make_display(8'd9, 16'h1234);
        send_frame(5, 1'b0);
        clear_stream();
        send_all(1'b0);
        send_all(1'b0);
        last_frame_bytes = pkt_bytes;
    endtask

    task automatic random_packet();
        int          pick;
        int          idx;
        logic [7:0]  len;
        pick = $urandom_range(99);
        if (pick < 40 || (pick < 55 && last_frame_bytes.size() == 0))
        begin
            make_display(pick_display_len(), rand_word());
            send_all($urandom_range(9) == 0);
            last_frame_bytes = pkt_bytes;
        end
        else if (pick < 55)
        begin
            pkt_bytes = last_frame_bytes;
            send_all($urandom_range(9) == 0);
        end
        else if (pick < 65)
        begin
            idx = $urandom_range(19);
            len = (idx < 9) ? TONE_LEN : (idx < 18) ? TONE_VOL_LEN
                                                      : 8'($urandom_range(20, TONE_VOL_LEN + 1));
            make_tone(len, pick_tone_word(), pick_tone_word(), rand_byte());
            send_all(rand_bit());
        end
        else if (pick < 70)
        begin
            make_heartbeat();
            send_all(rand_bit());
        end
        else if (pick < 75)
        begin
            if (rand_bit())
            begin
                start_frame(MIN_LENGTH);
            end
            else
            begin
                start_frame(HEARTBEAT_LEN);
                append_byte(rand_byte());
            end
            send_all(rand_bit());
        end
        else if (pick < 83)
        begin
            len = 8'($urandom_range(MIN_LENGTH - 1));
            if (cur_max < 8'hFF && rand_bit())
                len = 8'($urandom_range(255, int'(cur_max) + 1));
            if (cur_max < SYNC_FIRST && $urandom_range(3) == 0)
                len = SYNC_FIRST;
            start_frame(len);
            send_all(rand_bit());
        end
        else if (pick < 89)
        begin
            repeat ($urandom_range(6, 1))
                send_beat(1'b0, rand_byte(), rand_bit());
        end
        else if (pick < 94)
        begin
            make_display(pick_display_len(), rand_word());
            send_frame($urandom_range(pkt_bytes.size() - 1, 1), 1'b0);
            if (rand_bit())
                clear_stream();
        end
        else if (pick < 97 || last_frame_bytes.size() < SHORT_LIMIT)
        begin
            clear_stream();
        end
        else
        begin
            // last frame with one bit flipped past the header
            pkt_bytes = last_frame_bytes;
            idx = $urandom_range(pkt_bytes.size() - 1, 3);
            pkt_bytes[idx] = pkt_bytes[idx] ^ (8'h01 << $urandom_range(7));
            send_all(1'b0);
        end
    endtask

    initial
    begin
        int          mode;
        int          k;
        int          phase_end;
        logic [7:0]  limit;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        kind      <= 1'b0;
        data_byte <= '0;
        in_menu   <= 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 77;
        beats_sent    = 0;
        cur_max       = MAX_LEN_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 77 : 0;
            recv_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 24 : 0;
            for (k = 0; k < 5; k++)
            begin
                case (k)
                    0:       limit = MAX_LEN_RESET;
                    1:       limit = MIN_LENGTH;
                    2:       limit = 8'd0;
                    3:       limit = SYNC_FIRST - 8'd1;
                    default: limit = 8'($urandom_range(60, SHORT_LIMIT));
                endcase
                drain();
                write_limit(limit);
                phase_end = beats_sent + ((limit < MIN_LENGTH) ? 20 : PHASE_BEATS);
                while (beats_sent < phase_end)
                    random_packet();
            end
        end
        drain();
        if (fail_count == 0)
            $display("sync_length_packet_classifier_unit_test: PASS");
        else
            $display("sync_length_packet_classifier_unit_test: FAIL");
        $finish;
    end

endmodule
